// File: src/lbds_pkg.sv
`default_nettype none
package lbds_pkg;

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    REG_INV_BIN_WIDTH = 2'd0,
    REG_MAX_LAG       = 2'd1
  } reg_index_t;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] position;
    logic [31:0]        sample_time;
    logic [10:0]        bin_index;
  } in_word_t;

  typedef struct packed {
    logic [10:0] pairs_added;
    logic        history_overflow;
    logic [31:0] bin_count;
    logic [47:0] abs_sum;
    logic [63:0] square_sum;
    logic [31:0] mean_abs;
    logic        bin_empty;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_WALK_RD,
    ST_WALK_CALC,
    ST_WALK_BIN,
    ST_WALK_UPD,
    ST_ADD_DONE,
    ST_READ_RD,
    ST_READ_DIV,
    ST_RESULT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic clear_step;
    logic hist_read;
    logic pair_calc;
    logic bin_read;
    logic bin_write;
    logic walk_next;
    logic hist_write;
    logic read_issue;
    logic div_step;
    logic result_load;
  } cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic clear_last;
    logic walk_done;
    logic lag_stop;
    logic pair_valid;
    logic div_last;
  } status_t;

  localparam int DIV_STEPS = 48;
  localparam int DIV_CNT_W = 6;

endpackage
`default_nettype wire

// File: src/lbds_ctrl.sv
`default_nettype none
module lbds_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  input  wire [1:0]          in_func,
  input  wire                out_ready,
  input  wire                out_full,
  input  wire lbds_pkg::status_t sts,
  output logic               in_ready,
  output lbds_pkg::cmd_t     cmd
);
  import lbds_pkg::*;

  state_t state_r, state_nxt;

  // State register; reset starts with a clearing pass of the bin store.
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_INIT;
    else        state_r <= state_nxt;
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_INIT: begin
        // The clearing pass after reset produces no result word.
        cmd.clear_step = 1'b1;
        if (sts.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          case (func_t'(in_func))
            FUNC_ADD:   state_nxt = ST_WALK_RD;
            FUNC_READ:  state_nxt = ST_READ_RD;
            FUNC_CLEAR: state_nxt = ST_CLEAR;
            default:    state_nxt = ST_RESULT;
          endcase
        end
      end
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) state_nxt = ST_RESULT;
      end
      ST_WALK_RD: begin
        if (sts.walk_done) state_nxt = ST_ADD_DONE;
        else begin
          cmd.hist_read = 1'b1;
          state_nxt = ST_WALK_CALC;
        end
      end
      ST_WALK_CALC: begin
        cmd.pair_calc = 1'b1;
        state_nxt = ST_WALK_BIN;
      end
      ST_WALK_BIN: begin
        if (sts.lag_stop) state_nxt = ST_ADD_DONE;
        else if (sts.pair_valid) begin
          cmd.bin_read = 1'b1;
          state_nxt = ST_WALK_UPD;
        end else begin
          cmd.walk_next = 1'b1;
          state_nxt = ST_WALK_RD;
        end
      end
      ST_WALK_UPD: begin
        cmd.bin_write = 1'b1;
        cmd.walk_next = 1'b1;
        state_nxt = ST_WALK_RD;
      end
      ST_ADD_DONE: begin
        cmd.hist_write = 1'b1;
        state_nxt = ST_RESULT;
      end
      ST_READ_RD: begin
        cmd.read_issue = 1'b1;
        state_nxt = ST_READ_DIV;
      end
      ST_READ_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_full || out_ready) begin
          cmd.result_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: src/lbds_datapath.sv
`default_nettype none
module lbds_datapath #(
  parameter int HIST_DEPTH = 1024,
  parameter int NUM_BINS   = 2048
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire lbds_pkg::in_word_t in_data,
  input  wire lbds_pkg::cmd_t     cmd,
  input  wire [31:0]         inv_bin_width,
  input  wire [31:0]         max_lag,
  output lbds_pkg::status_t  sts,
  output lbds_pkg::out_word_t result
);
  import lbds_pkg::*;

  localparam int HW = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int FW = $clog2(HIST_DEPTH + 1);
  localparam int BW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  // History ring and bin store.
  logic signed [31:0] hist_pos_mem [HIST_DEPTH];
  logic [31:0]        hist_time_mem [HIST_DEPTH];
  logic [47:0]        abs_mem [NUM_BINS];
  logic [63:0]        sq_mem  [NUM_BINS];
  logic [31:0]        cnt_mem [NUM_BINS];

  in_word_t           item_r;
  logic [HW-1:0]      head_r;
  logic [FW-1:0]      fill_r;
  logic [FW-1:0]      walk_k_r;
  logic [10:0]        pairs_r;
  logic               stopped_r;
  logic               ovf_r;
  logic [BW-1:0]      clr_idx_r;
  logic signed [31:0] rd_pos_r;
  logic [31:0]        rd_time_r;
  logic               lag_neg_r, lag_big_r;
  logic [63:0]        prod_r;
  logic [32:0]        mag_r;
  logic [63:0]        sq_r;
  logic [BW-1:0]      bin_sel;
  logic               pair_ok;
  logic [47:0]        b_abs_r;
  logic [63:0]        b_sq_r;
  logic [31:0]        b_cnt_r;
  logic               rd_hit_r;
  logic [47:0]        quo_r;
  logic [32:0]        rem_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;

  // Address of the k-th newest kept sample, wrapped into the ring.
  logic [HW-1:0] rd_addr;
  logic [HW:0]   rd_diff;
  logic [HW:0]   rd_wrap;
  assign rd_diff = {1'b0, head_r} - (HW+1)'(walk_k_r) - (HW+1)'(1);
  assign rd_wrap = rd_diff + (HW+1)'(HIST_DEPTH);
  assign rd_addr = rd_diff[HW] ? rd_wrap[HW-1:0] : rd_diff[HW-1:0];

  // Lag and displacement of the current pair.
  logic signed [33:0] lag_w;
  logic signed [32:0] disp_w;
  logic [32:0]        mag_w;
  assign lag_w  = $signed({2'b00, item_r.sample_time}) - $signed({2'b00, rd_time_r});
  assign disp_w = 33'(item_r.position) - 33'(rd_pos_r);
  assign mag_w  = disp_w[32] ? 33'(-disp_w) : 33'(disp_w);

  // Bin number from the registered product.
  logic [40:0] bin_full;
  assign bin_full = 41'((prod_r + 64'h800000) >> 24);

  logic [48:0] abs_add;
  logic [64:0] sq_add;
  assign abs_add = {1'b0, b_abs_r} + {16'd0, mag_r};
  assign sq_add  = {1'b0, b_sq_r} + {1'b0, sq_r};

  logic [BW-1:0] rd_bin;
  assign rd_bin = BW'(item_r.bin_index);
  logic          rd_in_range;
  assign rd_in_range = ({21'd0, item_r.bin_index} < 32'(NUM_BINS));

  // Status toward the controller.
  always_comb begin
    sts.clear_last = (clr_idx_r == BW'(NUM_BINS - 1));
    sts.walk_done  = (walk_k_r == fill_r);
    sts.lag_stop   = lag_big_r;
    sts.pair_valid = pair_ok;
    sts.div_last   = (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
  end

  // Control registers of the walk and the ring.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      fill_r    <= '0;
      clr_idx_r <= '0;
      walk_k_r  <= '0;
      pairs_r   <= '0;
      stopped_r <= 1'b0;
      ovf_r     <= 1'b0;
      div_cnt_r <= '0;
    end else begin
      if (cmd.load_item) begin
        walk_k_r  <= '0;
        pairs_r   <= '0;
        stopped_r <= 1'b0;
        ovf_r     <= 1'b0;
        clr_idx_r <= '0;
        div_cnt_r <= '0;
      end
      if (cmd.clear_step) begin
        clr_idx_r <= clr_idx_r + BW'(1);
        head_r    <= '0;
        fill_r    <= '0;
      end
      if (cmd.walk_next) walk_k_r <= walk_k_r + FW'(1);
      if (cmd.bin_write) pairs_r <= pairs_r + 11'd1;
      if (cmd.pair_calc && lag_w > $signed({2'b00, max_lag})) stopped_r <= 1'b1;
      if (cmd.hist_write) begin
        // Overflow is judged on the fill before this sample is kept.
        ovf_r  <= (fill_r == FW'(HIST_DEPTH)) && !stopped_r;
        head_r <= (head_r == HW'(HIST_DEPTH - 1)) ? '0 : head_r + HW'(1);
        if (fill_r != FW'(HIST_DEPTH)) fill_r <= fill_r + FW'(1);
      end
      if (cmd.div_step) div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
    end
  end

  // Item capture, history reads and pair arithmetic.
  always_ff @(posedge clk) begin
    if (cmd.load_item) item_r <= in_data;
    if (cmd.hist_read) begin
      rd_pos_r  <= hist_pos_mem[rd_addr];
      rd_time_r <= hist_time_mem[rd_addr];
    end
    if (cmd.hist_write) begin
      hist_pos_mem[head_r]  <= item_r.position;
      hist_time_mem[head_r] <= item_r.sample_time;
    end
    if (cmd.pair_calc) begin
      lag_neg_r <= lag_w[33];
      lag_big_r <= lag_w > $signed({2'b00, max_lag});
      prod_r    <= 64'(lag_w[31:0]) * 64'(inv_bin_width);
      mag_r     <= mag_w;
      sq_r      <= 64'(mag_w[31:0]) * 64'(mag_w[31:0]);
    end
  end

  // Bin validity is judged from the registered product.
  always_comb begin
    pair_ok = !lag_neg_r && !lag_big_r && (bin_full != 41'd0)
              && (bin_full < 41'(NUM_BINS));
    bin_sel = bin_full[BW-1:0];
  end

  // Bin store: one read-modify-write per binned pair, one entry per cycle when clearing.
  logic [BW-1:0] upd_bin_r;
  always_ff @(posedge clk) begin
    if (cmd.bin_read) begin
      b_abs_r   <= abs_mem[bin_sel];
      b_sq_r    <= sq_mem[bin_sel];
      b_cnt_r   <= cnt_mem[bin_sel];
      upd_bin_r <= bin_sel;
    end
    if (cmd.read_issue) begin
      b_abs_r  <= abs_mem[rd_bin];
      b_sq_r   <= sq_mem[rd_bin];
      b_cnt_r  <= cnt_mem[rd_bin];
      rd_hit_r <= rd_in_range;
    end
    if (cmd.clear_step) begin
      abs_mem[clr_idx_r] <= '0;
      sq_mem[clr_idx_r]  <= '0;
      cnt_mem[clr_idx_r] <= '0;
    end else if (cmd.bin_write) begin
      abs_mem[upd_bin_r] <= abs_add[48] ? {48{1'b1}} : abs_add[47:0];
      sq_mem[upd_bin_r]  <= sq_add[64] ? {64{1'b1}} : sq_add[63:0];
      cnt_mem[upd_bin_r] <= (b_cnt_r == 32'hFFFFFFFF) ? b_cnt_r : b_cnt_r + 32'd1;
    end
  end

  // Restoring divider, one quotient bit per cycle.
  logic [33:0] rem_sh;
  logic [33:0] rem_sub;
  logic [47:0] quo_src;
  assign quo_src = (div_cnt_r == '0) ? b_abs_r : quo_r;
  assign rem_sh  = {(div_cnt_r == '0) ? 33'd0 : rem_r, quo_src[47]};
  assign rem_sub = rem_sh - {2'b00, b_cnt_r};
  always_ff @(posedge clk) begin
    if (cmd.div_step) begin
      if (!rem_sub[33]) begin
        rem_r <= rem_sub[32:0];
        quo_r <= {quo_src[46:0], 1'b1};
      end else begin
        rem_r <= rem_sh[32:0];
        quo_r <= {quo_src[46:0], 1'b0};
      end
    end
  end

  // Result assembly.
  logic rd_nonempty;
  assign rd_nonempty = rd_hit_r && (b_cnt_r != 32'd0);
  always_comb begin
    result = '0;
    case (func_t'(item_r.func))
      FUNC_ADD: begin
        result.pairs_added      = pairs_r;
        result.history_overflow = ovf_r;
      end
      FUNC_READ: begin
        result.bin_empty = !rd_nonempty;
        if (rd_nonempty) begin
          result.bin_count  = b_cnt_r;
          result.abs_sum    = b_abs_r;
          result.square_sum = b_sq_r;
          result.mean_abs   = (quo_r[47:32] != 16'd0) ? 32'hFFFFFFFF : quo_r[31:0];
        end
      end
      default: result = '0;
    endcase
  end
endmodule
`default_nettype wire

// File: src/lag_binned_displacement_stats.sv
`default_nettype none
// Lag-binned displacement statistics.
// Input channel (in_valid/in_ready/in_data) takes one word per command:
// add a sample, read a bin, or clear the history and all bins.
// Output channel (out_valid/out_ready/out_data) gives one word per command.
// Configuration writes (cfg_we/cfg_index/cfg_data) go to inv_bin_width
// and max_lag; they take effect at once and belong only where the block is idle.
// An add walks the history newest first, up to HIST_DEPTH pairs, reading
// each kept sample and binning each pair that falls in a bin by a
// read-modify-write of the single-port bin store, which sets the pace.
// A read divides the bin's absolute sum by its count in a one-bit-a-cycle divider.
// A clear wipes the bin store one entry per cycle.
// After reset the block runs the same clearing pass before in_ready rises;
// configuration is reset to its defaults.
// The result sits in an output register; while the receiver stalls the
// block finishes the next command and then holds it until the register frees.
module lag_binned_displacement_stats #(
  parameter int HIST_DEPTH = 1024,
  parameter int NUM_BINS   = 2048
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire lbds_pkg::in_word_t in_data,
  output logic               out_valid,
  input  wire                out_ready,
  output lbds_pkg::out_word_t out_data,
  input  wire                cfg_we,
  input  wire [1:0]          cfg_index,
  input  wire [31:0]         cfg_data
);
  import lbds_pkg::*;

  cmd_t      cmd;
  status_t   sts;
  out_word_t result;
  logic [31:0] inv_bin_width_r, max_lag_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_bin_width_r <= 32'd81920;
      max_lag_r       <= 32'd256000;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_INV_BIN_WIDTH: inv_bin_width_r <= cfg_data;
        REG_MAX_LAG:       max_lag_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  lbds_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_func(in_data.func), .out_ready,
    .out_full(out_valid), .sts, .in_ready, .cmd
  );

  lbds_datapath #(.HIST_DEPTH(HIST_DEPTH), .NUM_BINS(NUM_BINS)) u_dp (
    .clk, .rst_n, .in_data, .cmd, .inv_bin_width(inv_bin_width_r),
    .max_lag(max_lag_r), .sts, .result
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (cmd.result_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.result_load) out_data <= result;
  end
endmodule
`default_nettype wire

// File: src/lbds_checker.sv
`default_nettype none
module lbds_sva (
  input wire clk,
  input wire rst_n,
  input wire in_valid,
  input wire in_ready,
  input wire out_valid,
  input wire out_ready,
  input wire lbds_pkg::out_word_t out_data
);
  import lbds_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  a_no_accept_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted before result");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bin_empty |-> out_data.bin_count == 32'd0)
    else $error("empty bin with nonzero count");

  a_mean_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bin_count == 32'd0 |-> out_data.mean_abs == 32'd0)
    else $error("mean of empty bin nonzero");
endmodule

bind lag_binned_displacement_stats lbds_sva u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
`default_nettype wire

// File: bench/lbds_checker.sv
`timescale 1ns / 1ps
module lbds_checker
  import lbds_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  input  wire        in_ready,
  input  in_word_t   in_data,
  input  wire        out_valid,
  input  wire        out_ready,
  input  out_word_t  out_data,
  input  wire        cfg_we,
  input  wire [1:0]  cfg_index,
  input  wire [31:0] cfg_data,
  output int         errors,
  output int         pending
);

  localparam int DEPTH = 1024;
  localparam int BINS  = 2048;
  localparam int OWED_SLOTS = 16;

  // Shadow copy of the trajectory history, the bin store and the registers.
  logic signed [31:0] trail_pos[DEPTH];
  logic [31:0]        trail_time[DEPTH];
  int unsigned        trail_head;
  int unsigned        trail_fill;
  logic [47:0]        bin_abs[BINS];
  logic [63:0]        bin_sq[BINS];
  logic [31:0]        bin_pairs[BINS];
  logic [31:0]        inv_width;
  logic [31:0]        lag_limit;

  // Words the block still owes, oldest first, in a small ring.
  out_word_t   owed_words[OWED_SLOTS];
  int unsigned owed_wr;
  int unsigned owed_rd;

  initial begin
    errors = 0;
    pending = 0;
    owed_wr = 0;
    owed_rd = 0;
  end

  function automatic void wipe_store();
    trail_head = 0;
    trail_fill = 0;
    for (int i = 0; i < BINS; i++) begin
      bin_abs[i] = '0;
      bin_sq[i] = '0;
      bin_pairs[i] = '0;
    end
  endfunction

  // Folds one pair into its lag bin; returns 1 if the pair was binned.
  function automatic bit bin_pair(longint lag, longint disp);
    logic [63:0] prod;
    logic [64:0] rounded;
    logic [40:0] b;
    logic [63:0] mag;
    logic [63:0] sq;
    logic [48:0] asum;
    logic [64:0] ssum;
    if (lag < 0) return 1'b0;
    prod = 64'(lag[31:0]) * 64'(inv_width);
    rounded = {1'b0, prod} + 65'h800000;
    b = rounded[64:24];
    if (b == 0 || b >= BINS) return 1'b0;
    mag = (disp < 0) ? 64'(-disp) : 64'(disp);
    sq = mag * mag;
    asum = {1'b0, bin_abs[b]} + mag[48:0];
    bin_abs[b] = asum[48] ? '1 : asum[47:0];
    ssum = {1'b0, bin_sq[b]} + {1'b0, sq};
    bin_sq[b] = ssum[64] ? '1 : ssum[63:0];
    if (bin_pairs[b] != '1) bin_pairs[b]++;
    return 1'b1;
  endfunction

  // Applies one command word to the shadow state and returns the word it yields.
  function automatic out_word_t apply_command(in_word_t w);
    out_word_t r;
    int unsigned idx;
    int unsigned pairs;
    bit stopped;
    longint lag;
    logic [47:0] m;
    r = '0;
    case (func_t'(w.func))
      FUNC_ADD: begin
        pairs = 0;
        stopped = 1'b0;
        for (int unsigned k = 0; k < trail_fill; k++) begin
          idx = (trail_head + DEPTH - 1 - k) % DEPTH;
          lag = longint'(w.sample_time) - longint'(trail_time[idx]);
          if (lag > longint'(lag_limit)) begin
            stopped = 1'b1;
            break;
          end
          if (bin_pair(lag, longint'(w.position) - longint'(trail_pos[idx]))) pairs++;
        end
        r.pairs_added = pairs[10:0];
        r.history_overflow = (trail_fill >= DEPTH) && !stopped;
        trail_pos[trail_head] = w.position;
        trail_time[trail_head] = w.sample_time;
        trail_head = (trail_head + 1) % DEPTH;
        if (trail_fill < DEPTH) trail_fill++;
      end
      FUNC_READ: begin
        if (bin_pairs[w.bin_index] != 0) begin
          m = bin_abs[w.bin_index] / 48'(bin_pairs[w.bin_index]);
          r.bin_count = bin_pairs[w.bin_index];
          r.abs_sum = bin_abs[w.bin_index];
          r.square_sum = bin_sq[w.bin_index];
          r.mean_abs = (m > 48'hFFFF_FFFF) ? '1 : m[31:0];
        end else begin
          r.bin_empty = 1'b1;
        end
      end
      FUNC_CLEAR: begin
        wipe_store();
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Watches all three ports at each edge; results are compared before new words.
  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst_n) begin
      inv_width <= 32'd81920;
      lag_limit <= 32'd256000;
      wipe_store();
      owed_wr = 0;
      owed_rd = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_wr == owed_rd) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          exp_w = owed_words[owed_rd % OWED_SLOTS];
          owed_rd++;
          if (out_data.pairs_added !== exp_w.pairs_added) begin
            $error("pairs_added: expected %0d, got %0d", exp_w.pairs_added, out_data.pairs_added);
            errors++;
          end
          if (out_data.history_overflow !== exp_w.history_overflow) begin
            $error("history_overflow: expected %0d, got %0d", exp_w.history_overflow,
                   out_data.history_overflow);
            errors++;
          end
          if (out_data.bin_count !== exp_w.bin_count) begin
            $error("bin_count: expected %0d, got %0d", exp_w.bin_count, out_data.bin_count);
            errors++;
          end
          if (out_data.abs_sum !== exp_w.abs_sum) begin
            $error("abs_sum: expected %0d, got %0d", exp_w.abs_sum, out_data.abs_sum);
            errors++;
          end
          if (out_data.square_sum !== exp_w.square_sum) begin
            $error("square_sum: expected %0d, got %0d", exp_w.square_sum, out_data.square_sum);
            errors++;
          end
          if (out_data.mean_abs !== exp_w.mean_abs) begin
            $error("mean_abs: expected %0d, got %0d", exp_w.mean_abs, out_data.mean_abs);
            errors++;
          end
          if (out_data.bin_empty !== exp_w.bin_empty) begin
            $error("bin_empty: expected %0d, got %0d", exp_w.bin_empty, out_data.bin_empty);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        owed_words[owed_wr % OWED_SLOTS] = apply_command(in_data);
        owed_wr++;
      end
      if (cfg_we) begin
        if (reg_index_t'(cfg_index) == REG_INV_BIN_WIDTH) inv_width <= cfg_data;
        else if (reg_index_t'(cfg_index) == REG_MAX_LAG) lag_limit <= cfg_data;
      end
    end
    pending <= int'(owed_wr - owed_rd);
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import lbds_pkg::*;

  localparam int CYCLE_LIMIT = 15000000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int errors;
  int pending;
  int cycles = 0;
  bit calm = 1'b0;

  // Stimulus state for the random trajectory.
  logic [31:0] t_now;
  logic [31:0] p_now;

  always #5 clk = ~clk;

  lag_binned_displacement_stats DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  lbds_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  // Receiver stalls at random outside calm stretches.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 14);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Sends one word and holds it until accepted; unused fields carry noise.
  task automatic issue(func_t f, logic [31:0] pos, logic [31:0] t, logic [10:0] b);
    in_word_t w;
    w.func = f;
    w.position = (f == FUNC_ADD) ? pos : $urandom;
    w.sample_time = (f == FUNC_ADD) ? t : $urandom;
    w.bin_index = (f == FUNC_READ) ? b : 11'($urandom);
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!calm && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every owed word has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(reg_index_t i, logic [31:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= i;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One random stretch under a given setting of both registers.
  task automatic run_phase(logic [31:0] inv, logic [31:0] lim, int unsigned step_max,
                           int unsigned n);
    int unsigned pick;
    int unsigned top_bin;
    logic [63:0] span;
    set_reg(REG_INV_BIN_WIDTH, inv);
    set_reg(REG_MAX_LAG, lim);
    span = (64'(lim) * 64'(inv)) >> 24;
    top_bin = (span > 2046) ? 2047 : int'(span) + 1;
    t_now = $urandom_range(0, 1000000);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        if ($urandom_range(99) < 5) t_now = t_now - $urandom_range(0, step_max);
        else t_now = t_now + $urandom_range(0, step_max);
        if ($urandom_range(99) < 30) p_now = $urandom;
        else p_now = p_now + 32'($signed($urandom_range(0, 8000)) - 4000);
        issue(FUNC_ADD, p_now, t_now, '0);
      end else if (pick < 95) begin
        if ($urandom_range(99) < 70) issue(FUNC_READ, '0, '0, 11'($urandom_range(0, top_bin)));
        else issue(FUNC_READ, '0, '0, 11'($urandom_range(0, 2047)));
      end else if (pick < 98) begin
        issue(FUNC_CLEAR, '0, '0, '0);
      end else begin
        issue(FUNC_NONE, '0, '0, '0);
      end
    end
  endtask

  initial begin
    p_now = '0;
    t_now = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words under the reset setting: empty reads, zero and
    // negative lags, a lag past the limit, square-sum saturation, func 3.
    issue(FUNC_READ, '0, '0, 11'd0);
    issue(FUNC_READ, '0, '0, 11'd2047);
    issue(FUNC_ADD, 32'h0000_0000, 32'd0, '0);
    issue(FUNC_ADD, 32'h7FFF_FFFF, 32'd0, '0);
    issue(FUNC_ADD, 32'h8000_0000, 32'd256, '0);
    issue(FUNC_ADD, 32'h7FFF_FFFF, 32'd100, '0);
    issue(FUNC_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
    issue(FUNC_READ, '0, '0, 11'd1);
    issue(FUNC_READ, '0, '0, 11'd0);
    issue(FUNC_CLEAR, '0, '0, '0);
    issue(FUNC_READ, '0, '0, 11'd1);
    issue(FUNC_ADD, 32'h8000_0000, 32'd1000, '0);
    issue(FUNC_ADD, 32'h7FFF_FFFF, 32'd1256, '0);
    issue(FUNC_ADD, 32'h8000_0000, 32'd1512, '0);
    issue(FUNC_ADD, 32'h7FFF_FFFF, 32'd1768, '0);
    issue(FUNC_READ, '0, '0, 11'd1);
    issue(FUNC_READ, '0, '0, 11'd3);
    issue(FUNC_ADD, 32'h0000_0000, 32'd257768, '0);
    issue(FUNC_NONE, '0, '0, '0);
    issue(FUNC_READ, '0, '0, 11'd1250);

    // Random stretches under several settings, one of them with no idling.
    run_phase(32'd81920, 32'd256000, 25600, 110);
    calm = 1'b1;
    run_phase(32'hFFFF_FFFF, 32'd4000, 400, 100);
    calm = 1'b0;
    run_phase(32'd0, 32'd3000, 300, 80);
    run_phase(32'd1, 32'd0, 3, 70);
    run_phase(32'h0100_0000, 32'd2047, 200, 120);
    run_phase(32'h0004_0000, 32'hFFFF_FFFF, 64, 80);

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
